@@ rtl/core/pbspl_pkg.sv @@
// pbspl_pkg: shared constants and types for the periodic b-spline basis evaluator
// no dependencies
`default_nettype none
package pbspl_pkg;
    localparam int MAX_BASIS_D    = 16;
    localparam int MAX_DEGREE_D   = 7;
    localparam int VALUE_FRAC_D   = 15;
    localparam int INT_FRAC       = 28;
    localparam int PERIOD_W       = 32;
    localparam int DEGREE_W       = 3;
    localparam int NBASIS_W       = 5;
    localparam int CFG_ADDR_W     = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEGREE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_NBASIS  = 2'd2;

    typedef struct packed {
        logic        err;
        logic [31:0] xr;
        logic [31:0] per;
        logic [2:0]  deg;
        logic [4:0]  nb;
    } t_job;
endpackage
`default_nettype wire

@@ rtl/core/periodic_bspline_basis_eval.sv @@
// periodic_bspline_basis_eval: top level, config registers, front and back
// depends on pbspl_pkg, pbspl_front, pbspl_back
// A sample passes through the front (bit-serial modulo) and then the back: two serial
// divisions, the cox-de boor recursion with a serial division per new value, and one
// result per basis function; the shared serial divider sets the rate. Front and back overlap.
`default_nettype none
module periodic_bspline_basis_eval
    import pbspl_pkg::*;
#(
    parameter int MAX_BASIS  = MAX_BASIS_D,
    parameter int MAX_DEGREE = MAX_DEGREE_D,
    parameter int VALUE_FRAC = VALUE_FRAC_D
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [31:0]           i_sample,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [3:0]                 o_basis_index,
    output logic [15:0]                o_basis_value,
    output logic                       o_last,
    output logic                       o_config_error,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);
    logic [31:0] r_period;
    logic [2:0]  r_degree;
    logic [4:0]  r_n_basis;
    logic        f_valid, b_take;
    t_job        f_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= 32'd65536;
            r_degree  <= 3'd3;
            r_n_basis <= 5'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIOD: r_period  <= i_cfg_data;
                CFG_DEGREE: r_degree  <= i_cfg_data[2:0];
                CFG_NBASIS: r_n_basis <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    pbspl_front #(.MAX_BASIS(MAX_BASIS), .MAX_DEGREE(MAX_DEGREE)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_sample,
        .i_period(r_period), .i_degree(r_degree), .i_n_basis(r_n_basis),
        .o_valid(f_valid), .o_job(f_job), .i_take(b_take)
    );

    pbspl_back #(.MAX_BASIS(MAX_BASIS), .MAX_DEGREE(MAX_DEGREE),
                 .VALUE_FRAC(VALUE_FRAC)) u_back (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_job(f_job), .o_take(b_take),
        .o_empty(empty), .i_pop(pop), .o_basis_index, .o_basis_value,
        .o_last, .o_config_error
    );
endmodule
`default_nettype wire

@@ rtl/core/pbspl_front.sv @@
// pbspl_front: takes a sample, reduces it modulo the period, flags a bad configuration
// depends on pbspl_pkg; one bit per cycle restoring remainder
`default_nettype none
module pbspl_front
    import pbspl_pkg::*;
#(
    parameter int MAX_BASIS  = MAX_BASIS_D,
    parameter int MAX_DEGREE = MAX_DEGREE_D
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [31:0] i_sample,
    input  wire logic [31:0] i_period,
    input  wire logic [2:0]  i_degree,
    input  wire logic [4:0]  i_n_basis,
    output logic             o_valid,
    output t_job             o_job,
    input  wire logic        i_take
);
    logic        r_busy, r_neg;
    logic [5:0]  r_cnt;
    logic [31:0] r_mag;
    logic [32:0] r_rem;
    logic [32:0] n_rem_sh, n_rem;
    logic        bad;

    assign bad = (i_period == '0) || (i_n_basis == '0) ||
                 (33'(i_n_basis) > 33'(MAX_BASIS)) ||
                 (33'(i_degree) > 33'(MAX_DEGREE)) || (i_n_basis < 5'(i_degree));
    assign o_full = r_busy || o_valid;
    assign n_rem_sh = {r_rem[31:0], r_mag[31]};
    assign n_rem = (n_rem_sh >= {1'b0, o_job.per}) ? n_rem_sh - {1'b0, o_job.per} : n_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_take) o_valid <= 1'b0;
            if (i_push && !o_full) begin
                o_job.per <= i_period;
                o_job.deg <= i_degree;
                o_job.nb  <= i_n_basis;
                o_job.err <= bad;
                r_neg     <= i_sample[31];
                r_mag     <= i_sample[31] ? 32'(-i_sample) : i_sample;
                r_rem     <= '0;
                r_cnt     <= '0;
                if (bad) begin
                    o_job.xr <= '0;
                    o_valid  <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_mag <= {r_mag[30:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy   <= 1'b0;
                    o_valid  <= 1'b1;
                    o_job.xr <= (r_neg && n_rem[31:0] != '0) ?
                                o_job.per - n_rem[31:0] : n_rem[31:0];
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/pbspl_back.sv @@
// pbspl_back: span split, cox-de boor recursion, periodic wrap and result emission
// depends on pbspl_pkg; shared serial divider and one multiplier per cycle
`default_nettype none
module pbspl_back
    import pbspl_pkg::*;
#(
    parameter int MAX_BASIS  = MAX_BASIS_D,
    parameter int MAX_DEGREE = MAX_DEGREE_D,
    parameter int VALUE_FRAC = VALUE_FRAC_D
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  t_job             i_job,
    output logic             o_take,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [3:0]       o_basis_index,
    output logic [15:0]      o_basis_value,
    output logic             o_last,
    output logic             o_config_error
);
    localparam int NV   = MAX_DEGREE + 1;
    localparam int TW   = MAX_BASIS + MAX_DEGREE + 1;
    localparam int VW   = INT_FRAC + 2;
    localparam int NUMW = 70;
    typedef enum logic [3:0] {
        S_IDLE, S_DIVM, S_DIVF, S_SETQ, S_MUL1, S_MUL2, S_DIVN, S_PLACE, S_WRAP, S_EMIT,
        S_ERR
    } t_st;
    t_st          r_st;
    t_job         r_job;
    logic [VW-1:0]   r_nv [NV];
    logic [VW-1:0]   r_tmp [TW];
    logic [VW-1:0]   n_tmp [TW];
    logic [4:0]   r_m;
    logic [INT_FRAC-1:0] r_f;
    logic [NUMW-1:0] r_num;
    logic [NUMW-1:0] r_den;
    logic [NUMW-1:0] r_quo;
    logic [6:0]   r_cnt;
    logic [3:0]   r_q, r_j;
    logic [NUMW-1:0] r_acc;
    logic [4:0]   r_k;
    logic [NUMW-1:0] n_rem_sh;
    logic [NUMW-1:0] n_rem;
    logic [NUMW-1:0] n_quo;
    logic [NUMW-1:0] r_rem;
    logic [4:0]   shift;
    logic [5:0]   idx_s;
    logic [4:0]   idx;
    logic [VW-1:0] v_raw;
    logic [VW:0]  v_rnd;
    logic [15:0]  v_cap;
    logic [VW+4:0] a1, a2;
    logic [VW-1:0] p1, p2;
    logic         emit;

    assign o_take = (r_st == S_IDLE) && i_valid;
    assign emit = ((r_st == S_EMIT) || (r_st == S_ERR)) && (o_empty || i_pop);
    assign shift = (r_job.deg == '0) ? 5'd0 : 5'((r_job.deg - 3'd1) >> 1);
    assign idx_s = 6'(shift) + 6'(r_k);
    assign idx = (idx_s >= 6'(r_job.nb)) ? 5'(idx_s - 6'(r_job.nb)) : 5'(idx_s);
    assign v_raw = r_tmp[idx];
    localparam int SH = INT_FRAC - VALUE_FRAC;
    assign v_rnd = ({1'b0, v_raw} + (VW+1)'(1 << (SH - 1))) >> SH;
    assign v_cap = (v_rnd > (VW+1)'(1 << VALUE_FRAC)) ? 16'(1 << VALUE_FRAC) : 16'(v_rnd);
    assign n_rem_sh = {r_rem[NUMW-2:0], r_num[NUMW-1]};
    assign n_rem = (n_rem_sh >= r_den) ? n_rem_sh - r_den : n_rem_sh;
    assign n_quo = {r_quo[NUMW-2:0], n_rem_sh >= r_den};
    assign p1 = (r_j >= 4'd1) ? r_nv[3'(r_j - 4'd1)] : '0;
    assign p2 = (r_j < r_q) ? r_nv[3'(r_j)] : '0;
    assign a1 = (VW+5)'({4'(r_q - r_j), r_f});
    assign a2 = (VW+5)'({4'(r_j + 4'd1), {INT_FRAC{1'b0}}}) - (VW+5)'(r_f);

    // place the active span values at m .. m+degree
    always_comb begin
        for (int t = 0; t < TW; t++) begin
            n_tmp[t] = '0;
            for (int j = 0; j < NV; j++)
                if (j <= int'(r_job.deg) && t == int'(r_m) + j) n_tmp[t] = r_nv[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_empty <= 1'b1;
        end else begin
            if (emit) o_empty <= 1'b0;
            else if (!o_empty && i_pop) o_empty <= 1'b1;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    if (i_job.err) r_st <= S_ERR;
                    else begin
                        r_num  <= NUMW'(64'(i_job.xr) * 64'(i_job.nb));
                        r_den  <= NUMW'(i_job.per);
                        r_rem  <= '0;
                        r_cnt  <= '0;
                        r_st   <= S_DIVM;
                    end
                end
                S_DIVM, S_DIVF, S_DIVN: begin
                    if (r_cnt != 7'(NUMW - 1)) begin
                        r_num <= {r_num[NUMW-2:0], 1'b0};
                        r_rem <= n_rem;
                        r_quo <= n_quo;
                        r_cnt <= r_cnt + 7'd1;
                    end else begin
                        r_cnt <= '0;
                        if (r_st == S_DIVM) begin
                            r_m   <= 5'(n_quo);
                            r_num <= n_rem << INT_FRAC;
                            r_rem <= '0;
                            r_st  <= S_DIVF;
                        end else if (r_st == S_DIVF) begin
                            r_f     <= INT_FRAC'(n_quo);
                            r_nv[0] <= VW'(1) << INT_FRAC;
                            for (int i = 1; i < NV; i++) r_nv[i] <= '0;
                            r_q  <= 4'd1;
                            r_st <= (r_job.deg == '0) ? S_PLACE : S_SETQ;
                        end else begin
                            r_nv[3'(r_j)] <= VW'(n_quo);
                            if (r_j == '0) begin
                                if (r_q == 4'(r_job.deg)) r_st <= S_PLACE;
                                else begin
                                    r_q  <= r_q + 4'd1;
                                    r_st <= S_SETQ;
                                end
                            end else begin
                                r_j  <= r_j - 4'd1;
                                r_st <= S_MUL1;
                            end
                        end
                    end
                end
                S_SETQ: begin
                    r_j  <= r_q;
                    r_st <= S_MUL1;
                end
                S_MUL1: begin
                    r_acc <= NUMW'(a1) * NUMW'(p1);
                    r_st  <= S_MUL2;
                end
                S_MUL2: begin
                    r_num <= r_acc + NUMW'(a2) * NUMW'(p2) +
                             (NUMW'(r_q) << (INT_FRAC - 1));
                    r_den <= NUMW'(r_q) << INT_FRAC;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_st  <= S_DIVN;
                end
                S_PLACE: begin
                    for (int t = 0; t < TW; t++) r_tmp[t] <= n_tmp[t];
                    r_st <= S_WRAP;
                end
                S_WRAP: begin
                    for (int t = 0; t < NV; t++)
                        if (t < int'(r_job.deg))
                            r_tmp[t] <= r_tmp[t] + r_tmp[int'(r_job.nb) + t];
                    r_k  <= '0;
                    r_st <= S_EMIT;
                end
                S_EMIT: if (emit) begin
                    o_basis_index  <= 4'(r_k);
                    o_basis_value  <= v_cap;
                    o_last         <= r_k == r_job.nb - 5'd1;
                    o_config_error <= 1'b0;
                    r_k            <= r_k + 5'd1;
                    if (r_k == r_job.nb - 5'd1) r_st <= S_IDLE;
                end
                S_ERR: if (emit) begin
                    o_basis_index  <= '0;
                    o_basis_value  <= '0;
                    o_last         <= 1'b1;
                    o_config_error <= 1'b1;
                    r_st           <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_config_error |-> o_last)
        else $error("error result not last");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_st != S_IDLE)
        else $error("job taken but idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_config_error |-> o_basis_value <= 16'(1 << VALUE_FRAC))
        else $error("value above one");
endmodule
`default_nettype wire
